// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helper macros
// concurrent checks clocked on the rising edge, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check held while out of reset
`define RMPF_ASSERT_RST(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// check held at every edge, reset included
`define RMPF_ASSERT_ALW(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RMPF_ASSERT_RST(lbl, clk_i, rstn_i, prop, msg)
`define RMPF_ASSERT_ALW(lbl, clk_i, prop, msg)
`endif

`endif

// File: rtl/core/rmpf_pkg.sv
// ----------------------------------------------------------------------------
// rmpf_pkg
// types and constants of the response matcher with pending byte fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmpf_pkg;

  // budget register width and reset value
  localparam int unsigned BUDGET_W = 24;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd10000000;

  // terminator byte of a response frame
  localparam logic [7:0] TERM_BYTE = 8'hFF;

  // match progress after the code byte and two terminators
  localparam logic [1:0] PROG_LAST = 2'd3;

  // item kinds
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_POLL  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // result codes
  typedef enum logic [2:0] {
    ST_WAITING  = 3'd0,
    ST_MATCHED  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_BYTE     = 3'd4,
    ST_NOTHING  = 3'd5
  } status_t;

  // per-word info carried from the update stage to the read-data stage
  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       from_mem;
  } stage_info_t;

endpackage

`default_nettype wire

// File: rtl/core/response_matcher_with_pending_fifo.sv
// ----------------------------------------------------------------------------
// response_matcher_with_pending_fifo
// watches received bytes for a code byte plus three 0xFF bytes, keeps the
// stray bytes in a pending fifo memory and serves read requests from it
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per step; in_tuser carries the kind (start, received
//           byte, idle poll, read request), in_tdata the code, byte and flag.
//   out_* : exactly one result word per input word, in order; out_tuser holds
//           the status, out_tdata the delivered byte and the fifo fill.
//   cfg_* : writes the 24-bit poll budget loaded by a start word; always ready.
//   Path: first stage register, then output register. Throughput: one word
//   per cycle while the output is not stalled; the match state lives in
//   flip-flops and the pending fifo is a one-port-write, one-port-read memory
//   with registered read data, so every kind of word completes in one update.
//   Reset: clears the matcher, the fifo pointers and fill, and loads the
//   budget register with 10000000; the fifo memory itself is not cleared.
//   Stall: with out_tready low the output register and one stage behind it
//   hold their words; in_tready drops only once both are occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module response_matcher_with_pending_fifo #(
  parameter int unsigned PENDING_DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(PENDING_DEPTH),
  localparam int unsigned CNT_W  = $clog2(PENDING_DEPTH + 1),
  localparam int unsigned OUT_W  = ((8 + CNT_W + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,  // expect_code, rx_byte, hw_valid
  input  wire logic [1:0]                    in_tuser,  // kind
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [OUT_W-1:0]                   out_tdata, // data_byte, pending_count
  output logic [2:0]                         out_tuser, // status
  // budget register write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rmpf_pkg::BUDGET_W-1:0] cfg_data
);

  localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(PENDING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(PENDING_DEPTH);

  // input word fields
  rmpf_pkg::kind_t in_kind;
  logic [7:0]      in_code;
  logic [7:0]      in_rx;
  logic            in_hw;
  logic            in_acc;

  assign in_kind = rmpf_pkg::kind_t'(in_tuser);
  assign in_code = in_tdata[7:0];
  assign in_rx   = in_tdata[15:8];
  assign in_hw   = in_tdata[16];

  // matcher and fifo state
  logic [rmpf_pkg::BUDGET_W-1:0] timeout_r;
  logic                          waiting_r, waiting_nxt;
  logic [1:0]                    prog_r, prog_nxt;
  logic [7:0]                    armed_r, armed_nxt;
  logic [rmpf_pkg::BUDGET_W-1:0] budget_r, budget_nxt;
  logic [ADDR_W-1:0]             head_r, head_nxt;
  logic [ADDR_W-1:0]             tail_r, tail_nxt;
  logic [CNT_W-1:0]              fill_r, fill_nxt;

  // pending byte memory
  logic [7:0]                    pend_mem [PENDING_DEPTH];
  logic [7:0]                    rdata_r;
  logic                          push;
  logic                          pop;

  // pipeline registers
  logic                          p1_valid_r;
  rmpf_pkg::stage_info_t         p1_info_r, p1_info_nxt;
  logic [CNT_W-1:0]              p1_count_r;
  logic                          p1_adv;
  logic                          out_valid_r;
  rmpf_pkg::status_t             out_status_r;
  logic [7:0]                    out_data_r;
  logic [CNT_W-1:0]              out_count_r;

  // handshakes
  assign p1_adv    = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || p1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rmpf_pkg::BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // step update: matcher, budget and fifo bookkeeping
  always_comb begin
    logic [rmpf_pkg::BUDGET_W-1:0] bdec;
    logic                          fifo_full;
    logic                          finish;
    rmpf_pkg::status_t             st;

    waiting_nxt = waiting_r;
    prog_nxt    = prog_r;
    armed_nxt   = armed_r;
    budget_nxt  = budget_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    push        = 1'b0;
    pop         = 1'b0;
    finish      = 1'b0;
    st          = rmpf_pkg::ST_NOTHING;
    bdec        = budget_r - 1'b1;
    fifo_full   = (fill_r == CNT_FULL);
    p1_info_nxt = '{status: rmpf_pkg::ST_NOTHING, data: 8'h00, from_mem: 1'b0};

    case (in_kind)
      rmpf_pkg::KIND_START: begin
        armed_nxt  = in_code;
        budget_nxt = timeout_r;
        prog_nxt   = 2'd0;
        if (timeout_r == '0) begin
          waiting_nxt = 1'b0;
          st          = rmpf_pkg::ST_TIMEOUT;
        end else begin
          waiting_nxt = 1'b1;
          st          = rmpf_pkg::ST_WAITING;
        end
      end
      rmpf_pkg::KIND_BYTE, rmpf_pkg::KIND_POLL: begin
        if (waiting_r) begin
          budget_nxt = bdec;
          st         = rmpf_pkg::ST_WAITING;
          if (in_kind == rmpf_pkg::KIND_BYTE) begin
            if (prog_r == 2'd0) begin
              if (in_rx == armed_r) begin
                prog_nxt = 2'd1;
              end else if (fifo_full) begin
                finish = 1'b1;
                st     = rmpf_pkg::ST_OVERFLOW;
              end else begin
                push = 1'b1;
              end
            end else if (in_rx == rmpf_pkg::TERM_BYTE) begin
              if (prog_r == rmpf_pkg::PROG_LAST) begin
                finish = 1'b1;
                st     = rmpf_pkg::ST_MATCHED;
              end else begin
                prog_nxt = prog_r + 1'b1;
              end
            end else if (in_rx == armed_r) begin
              prog_nxt = 2'd1;
            end else begin
              prog_nxt = 2'd0;
              if (fifo_full) begin
                finish = 1'b1;
                st     = rmpf_pkg::ST_OVERFLOW;
              end else begin
                push = 1'b1;
              end
            end
          end
          // last unit spent without a frame end
          if (st == rmpf_pkg::ST_WAITING && bdec == '0) begin
            finish = 1'b1;
            st     = rmpf_pkg::ST_TIMEOUT;
          end
          if (finish) begin
            waiting_nxt = 1'b0;
            prog_nxt    = 2'd0;
          end
        end
      end
      rmpf_pkg::KIND_READ: begin
        if (fill_r != '0) begin
          pop                  = 1'b1;
          st                   = rmpf_pkg::ST_BYTE;
          p1_info_nxt.from_mem = 1'b1;
        end else if (in_hw) begin
          st               = rmpf_pkg::ST_BYTE;
          p1_info_nxt.data = in_rx;
        end
      end
      default: begin
        st = rmpf_pkg::ST_NOTHING;
      end
    endcase

    // pointer and fill movement
    if (push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end

    p1_info_nxt.status = st;
  end

  // state registers, updated once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      prog_r    <= 2'd0;
      armed_r   <= 8'h00;
      budget_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
    end else if (in_acc) begin
      waiting_r <= waiting_nxt;
      prog_r    <= prog_nxt;
      armed_r   <= armed_nxt;
      budget_r  <= budget_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // fifo memory: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (in_acc && push) begin
      pend_mem[tail_r] <= in_rx;
    end
    if (in_acc && pop) begin
      rdata_r <= pend_mem[head_r];
    end
  end

  // first stage: waits for the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (in_tready) begin
      p1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_info_r  <= p1_info_nxt;
      p1_count_r <= fill_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_status_r <= p1_info_r.status;
      out_data_r   <= p1_info_r.from_mem ? rdata_r : p1_info_r.data;
      out_count_r  <= p1_count_r;
    end
  end

  // result word packing
  always_comb begin
    out_tdata              = '0;
    out_tdata[7:0]         = out_data_r;
    out_tdata[8 +: CNT_W]  = out_count_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;

  // checks
  `RMPF_ASSERT_RST(a_fill_bound, clk, rst_n, (fill_r <= CNT_FULL), "pending fill above depth")
  `RMPF_ASSERT_RST(a_empty_ptrs, clk, rst_n, (fill_r == '0) |-> (head_r == tail_r), "empty fifo with split pointers")
  `RMPF_ASSERT_RST(a_idle_prog, clk, rst_n, (!waiting_r) |-> (prog_r == 2'd0), "match progress while idle")
  `RMPF_ASSERT_RST(a_p1_hold, clk, rst_n, (p1_valid_r && !p1_adv) |=> (p1_valid_r && $stable(p1_info_r)), "stage word lost under stall")

endmodule

`default_nettype wire
